/* hdl/thc_pkg.sv */
package thc_pkg;

  // Pipeline depth from accepted request to result register
  localparam int NUM_STAGES = 15;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_VALUE_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEFF_1  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEFF_2  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEFF_3  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HUM_COEFF_1_3 = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HUM_COEFF_2   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HUM_COEFF_4   = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HUM_COEFF_5   = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_HUM_COEFF_6   = 4'd7;

  // Compensation constants
  localparam logic [31:0] TEMP_ROUND      = 32'd128;
  localparam logic [31:0] T_FINE_OFFSET   = 32'd76800;
  localparam logic [31:0] HUM_ROUND       = 32'd16384;
  localparam logic [31:0] HUM_BIAS        = 32'd32768;
  localparam logic [31:0] HUM_SCALE_BIAS  = 32'd2097152;
  localparam logic [31:0] HUM_SCALE_ROUND = 32'd8192;
  localparam logic [31:0] HUM_MAX         = 32'd419430400;
  localparam int          HUM_SHIFT       = 22;
  localparam logic [6:0]  HUM_PCT_MAX     = 7'd100;

  // Divide by ten: floor(n / 10) = (n * DIV10_MAGIC) >> DIV10_SHIFT for n < 2^26
  localparam logic [23:0] DIV10_MAGIC = 24'd13421773;
  localparam int          DIV10_SHIFT = 27;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } reading_t;

  typedef struct packed {
    logic signed [31:0] temp_fine;
    logic signed [15:0] temperature_tenths;
    logic        [6:0]  humidity_percent;
  } result_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_VALUE_W-1:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic        [15:0] temp_coeff_1;
    logic signed [15:0] temp_coeff_2;
    logic signed [15:0] temp_coeff_3;
    logic        [15:0] hum_coeff_1_3;
    logic signed [15:0] hum_coeff_2;
    logic signed [11:0] hum_coeff_4;
    logic signed [11:0] hum_coeff_5;
    logic signed [7:0]  hum_coeff_6;
  } coeff_t;

  // Arithmetic right shift of a 32-bit word
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

endpackage

/* hdl/thc_if.sv */
// Input reading channel
interface thc_reading_if;
  logic              valid;
  logic              ready;
  thc_pkg::reading_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface thc_result_if;
  logic             valid;
  logic             ready;
  thc_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel
interface thc_cfg_if;
  logic                valid;
  logic                ready;
  thc_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/thc_temp.sv */
// Stages 1..4: fine temperature, plus the humidity offset term
module thc_temp (
  input  logic              clk,
  input  logic              en,
  input  thc_pkg::reading_t reading,
  input  thc_pkg::coeff_t   coeff,
  output logic [31:0]       temp_fine,
  output logic [31:0]       hum_base
);

  logic [31:0] c2;
  logic [31:0] c3;
  logic [31:0] d1;
  logic [31:0] d2;
  logic [31:0] base_s1;
  logic [31:0] p1;
  logic [31:0] p2;
  logic [31:0] base_s2;
  logic [31:0] var1;
  logic [31:0] m3;
  logic [31:0] base_s3;

  assign c2 = {{16{coeff.temp_coeff_2[15]}}, coeff.temp_coeff_2};
  assign c3 = {{16{coeff.temp_coeff_3[15]}}, coeff.temp_coeff_3};

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offsets against the calibration point
      d1      <= {15'b0, reading.raw_temperature[19:3]} - {15'b0, coeff.temp_coeff_1, 1'b0};
      d2      <= {16'b0, reading.raw_temperature[19:4]} - {16'b0, coeff.temp_coeff_1};
      base_s1 <= {2'b0, reading.raw_humidity, 14'b0} - {coeff.hum_coeff_4, 20'b0}
                 + thc_pkg::HUM_ROUND;
      // stage 2: linear and square products
      p1      <= d1 * c2;
      p2      <= d2 * d2;
      base_s2 <= base_s1;
      // stage 3: scale, quadratic coefficient
      var1    <= thc_pkg::asr(p1, 11);
      m3      <= thc_pkg::asr(p2, 12) * c3;
      base_s3 <= base_s2;
      // stage 4: fine temperature
      temp_fine <= var1 + thc_pkg::asr(m3, 14);
      hum_base  <= base_s3;
    end
  end

endmodule

/* hdl/thc_tenths.sv */
// Stages 5..NUM_STAGES: temperature in tenths of a degree, fine value carried along
module thc_tenths (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] temp_fine,
  output logic [31:0] temp_fine_out,
  output logic [15:0] tenths_out
);

  localparam int DELAY = thc_pkg::NUM_STAGES - 8;
  localparam int QW    = 48 - thc_pkg::DIV10_SHIFT;

  logic [31:0]   tq_full;
  logic [23:0]   t5;
  logic [31:0]   tf5;
  logic          neg6;
  logic [23:0]   mag6;
  logic [31:0]   tf6;
  logic          neg7;
  logic [47:0]   prod7;
  logic [31:0]   tf7;
  logic [QW-1:0] quo;
  logic [QW-1:0] quo_neg;
  logic [15:0]   tenths8;
  logic [31:0]   tf8;
  logic [31:0]   tf_dly  [DELAY];
  logic [15:0]   ten_dly [DELAY];

  // (tf * 5 + 128) >> 8, fits 24 signed bits
  assign tq_full = thc_pkg::asr({temp_fine[29:0], 2'b00} + temp_fine + thc_pkg::TEMP_ROUND, 8);
  assign quo     = prod7[47:thc_pkg::DIV10_SHIFT];
  assign quo_neg = '0 - quo;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 5
      t5    <= tq_full[23:0];
      tf5   <= temp_fine;
      // stage 6: magnitude for truncating division
      neg6  <= t5[23];
      mag6  <= t5[23] ? (24'd0 - t5) : t5;
      tf6   <= tf5;
      // stage 7: reciprocal multiply
      neg7  <= neg6;
      prod7 <= 48'(mag6) * 48'(thc_pkg::DIV10_MAGIC);
      tf7   <= tf6;
      // stage 8: restore sign, saturate to 16 bits
      if (neg7) begin
        tenths8 <= (quo > QW'(32768)) ? 16'h8000 : quo_neg[15:0];
      end else begin
        tenths8 <= (quo > QW'(32767)) ? 16'h7fff : quo[15:0];
      end
      tf8 <= tf7;
      // alignment with the humidity path
      tf_dly[0]  <= tf8;
      ten_dly[0] <= tenths8;
      for (int i = 1; i < DELAY; i++) begin
        tf_dly[i]  <= tf_dly[i-1];
        ten_dly[i] <= ten_dly[i-1];
      end
    end
  end

  assign temp_fine_out = tf_dly[DELAY-1];
  assign tenths_out    = ten_dly[DELAY-1];

endmodule

/* hdl/thc_hum.sv */
// Stages 5..15: relative humidity
module thc_hum (
  input  logic            clk,
  input  logic            en,
  input  logic [31:0]     temp_fine,
  input  logic [31:0]     hum_base,
  input  thc_pkg::coeff_t coeff,
  output logic [6:0]      humidity_percent
);

  logic [31:0] h1;
  logic [31:0] h2;
  logic [31:0] h3;
  logic [31:0] h5;
  logic [31:0] h6;
  logic [31:0] v5;
  logic [31:0] base5;
  logic [31:0] p5;
  logic [31:0] p6;
  logic [31:0] p3;
  logic [31:0] base6;
  logic [31:0] a7;
  logic [31:0] b1_7;
  logic [31:0] b2_7;
  logic [31:0] bp8;
  logic [31:0] a8;
  logic [31:0] b9;
  logic [31:0] a9;
  logic [31:0] bm10;
  logic [31:0] a10;
  logic [31:0] b11;
  logic [31:0] a11;
  logic [31:0] x12;
  logic [31:0] s12;
  logic [31:0] ss13;
  logic [31:0] x13;
  logic [31:0] qm14;
  logic [31:0] x14;
  logic [31:0] xd;

  assign h1 = {24'b0, coeff.hum_coeff_1_3[7:0]};
  assign h3 = {24'b0, coeff.hum_coeff_1_3[15:8]};
  assign h2 = {{16{coeff.hum_coeff_2[15]}}, coeff.hum_coeff_2};
  assign h5 = {{20{coeff.hum_coeff_5[11]}}, coeff.hum_coeff_5};
  assign h6 = {{24{coeff.hum_coeff_6[7]}}, coeff.hum_coeff_6};

  assign s12 = thc_pkg::asr(x12, 15);
  assign xd  = x14 - thc_pkg::asr(qm14, 4);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 5: temperature relative to 15 degrees
      v5    <= temp_fine - thc_pkg::T_FINE_OFFSET;
      base5 <= hum_base;
      // stage 6: temperature products
      p5    <= h5 * v5;
      p6    <= v5 * h6;
      p3    <= v5 * h3;
      base6 <= base5;
      // stage 7: offset term and scale factors
      a7    <= thc_pkg::asr(base6 - p5, 15);
      b1_7  <= thc_pkg::asr(p6, 10);
      b2_7  <= thc_pkg::asr(p3, 11) + thc_pkg::HUM_BIAS;
      // stage 8
      bp8   <= b1_7 * b2_7;
      a8    <= a7;
      // stage 9
      b9    <= thc_pkg::asr(bp8, 10) + thc_pkg::HUM_SCALE_BIAS;
      a9    <= a8;
      // stage 10
      bm10  <= b9 * h2;
      a10   <= a9;
      // stage 11
      b11   <= thc_pkg::asr(bm10 + thc_pkg::HUM_SCALE_ROUND, 14);
      a11   <= a10;
      // stage 12: raw humidity word
      x12   <= a11 * b11;
      // stage 13: square for the correction term
      ss13  <= s12 * s12;
      x13   <= x12;
      // stage 14
      qm14  <= thc_pkg::asr(ss13, 7) * h1;
      x14   <= x13;
      // stage 15: correct, clamp, scale to percent
      if ($signed(xd) < 0) begin
        humidity_percent <= '0;
      end else if ($signed(xd) > $signed(thc_pkg::HUM_MAX)) begin
        humidity_percent <= thc_pkg::HUM_PCT_MAX;
      end else begin
        humidity_percent <= xd[thc_pkg::HUM_SHIFT+6:thc_pkg::HUM_SHIFT];
      end
    end
  end

endmodule

/* hdl/thc_out.sv */
// Valid pipeline and output skid register
module thc_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  thc_pkg::result_t last,
  output logic             en,
  thc_result_if.source     result
);

  localparam int N = thc_pkg::NUM_STAGES;

  logic [N-1:0]     vld;
  logic             skid_full;
  thc_pkg::result_t skid;

  // pipeline moves whenever the skid register is free
  assign en = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      skid_full <= 1'b0;
    end else begin
      if (en) begin
        vld <= {vld[N-2:0], in_valid};
        if (vld[N-1] && !result.ready) begin
          skid_full <= 1'b1;
        end
      end else if (result.ready) begin
        skid_full <= 1'b0;
      end
    end
  end

  // capture a stalled result so the pipeline can advance once more before it holds
  always_ff @(posedge clk) begin
    if (en && vld[N-1] && !result.ready) begin
      skid <= last;
    end
  end

  assign result.valid = skid_full || vld[N-1];
  assign result.data  = skid_full ? skid : last;

endmodule

/* hdl/temp_humidity_compensation.sv */
// Temperature and humidity compensation.
// reading: one request carries a raw 20-bit temperature and a raw 16-bit
//   humidity conversion; it is taken when valid and ready are both high.
// result: one result per request, in order: fine temperature, temperature in
//   tenths of a degree (truncated, saturated to 16 bits) and humidity in whole
//   percent (0..100).
// cfg: writes the eight calibration registers by index; indexes above seven
//   are ignored. ready is always high. Write only while no request is in flight.
// Pipeline: 15 register stages. No stage holds more than one 32-bit multiply
//   in series.
// Throughput: one request per cycle while the skid register is free.
// Stall: when result is not taken, the pipeline advances once more into a skid
//   register and then holds; reading.ready falls until the skid drains.
//   Nothing is lost or repeated.
// Reset (rst, synchronous): clears all valid bits, the skid full flag and
//   the calibration registers to zero.
module temp_humidity_compensation (
  input  logic          clk,
  input  logic          rst,
  thc_reading_if.sink   reading,
  thc_cfg_if.sink       cfg,
  thc_result_if.source  result
);

  thc_pkg::coeff_t  coeff;
  thc_pkg::result_t last;
  logic             en;
  logic [31:0]      temp_fine_s4;
  logic [31:0]      hum_base_s4;
  logic [31:0]      temp_fine_last;
  logic [15:0]      tenths_last;
  logic [6:0]       pct_last;

  // calibration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.index)
        thc_pkg::REG_TEMP_COEFF_1:  coeff.temp_coeff_1  <= cfg.data.value;
        thc_pkg::REG_TEMP_COEFF_2:  coeff.temp_coeff_2  <= cfg.data.value;
        thc_pkg::REG_TEMP_COEFF_3:  coeff.temp_coeff_3  <= cfg.data.value;
        thc_pkg::REG_HUM_COEFF_1_3: coeff.hum_coeff_1_3 <= cfg.data.value;
        thc_pkg::REG_HUM_COEFF_2:   coeff.hum_coeff_2   <= cfg.data.value;
        thc_pkg::REG_HUM_COEFF_4:   coeff.hum_coeff_4   <= cfg.data.value[11:0];
        thc_pkg::REG_HUM_COEFF_5:   coeff.hum_coeff_5   <= cfg.data.value[11:0];
        thc_pkg::REG_HUM_COEFF_6:   coeff.hum_coeff_6   <= cfg.data.value[7:0];
        default: ;
      endcase
    end
  end

  assign reading.ready = en;

  thc_temp u_temp (
    .clk       (clk),
    .en        (en),
    .reading   (reading.data),
    .coeff     (coeff),
    .temp_fine (temp_fine_s4),
    .hum_base  (hum_base_s4)
  );

  thc_tenths u_tenths (
    .clk           (clk),
    .en            (en),
    .temp_fine     (temp_fine_s4),
    .temp_fine_out (temp_fine_last),
    .tenths_out    (tenths_last)
  );

  thc_hum u_hum (
    .clk              (clk),
    .en               (en),
    .temp_fine        (temp_fine_s4),
    .hum_base         (hum_base_s4),
    .coeff            (coeff),
    .humidity_percent (pct_last)
  );

  assign last.temp_fine          = temp_fine_last;
  assign last.temperature_tenths = tenths_last;
  assign last.humidity_percent   = pct_last;

  thc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (reading.valid),
    .last     (last),
    .en       (en),
    .result   (result)
  );

endmodule
